// ===== rtl/core/mfm_pkg.sv =====
// Shared types and constants for the multi-slot alpha fade mixer.
`default_nettype none
package mfm_pkg;

  localparam int unsigned SlotsDefault = 8;
  localparam int unsigned WeightW      = 17;
  localparam int unsigned TimeW        = 24;
  localparam int unsigned ElapsedW     = 16;
  localparam int unsigned ProdW        = WeightW + TimeW;
  localparam int unsigned QuotW        = 17;

  localparam logic [WeightW-1:0] OneQ16   = 17'h10000;
  localparam logic [TimeW-1:0]   ClockMax = 24'hFFFFFF;

  typedef enum logic [1:0] {
    CmdTick     = 2'd0,
    CmdAddConst = 2'd1,
    CmdAddRamp  = 2'd2,
    CmdRemove   = 2'd3
  } cmd_e;

  typedef enum logic [5:0] {
    StIdle = 6'b000001,
    StScan = 6'b000010,
    StMulR = 6'b000100,
    StDiv  = 6'b001000,
    StAcc  = 6'b010000,
    StOut  = 6'b100000
  } state_e;

  typedef struct packed {
    logic start;
    logic done;
  } div_ctl_t;

endpackage
`default_nettype wire

// ===== rtl/core/mfm_divider.sv =====
// Restoring bit-serial divider that yields one quotient bit per cycle.
`default_nettype none
module mfm_divider (
  input  wire logic                             clk_i,
  input  wire logic                             rst_ni,
  input  wire logic                             start_i,
  input  wire logic [mfm_pkg::ProdW-1:0]        num_i,
  input  wire logic [mfm_pkg::TimeW-1:0]        den_i,
  output logic                                  done_o,
  output logic      [mfm_pkg::QuotW-1:0]        quot_o
);

  localparam int unsigned CntW = $clog2(mfm_pkg::QuotW + 1);

  logic [mfm_pkg::TimeW-1:0] rem_q, rem_d;
  logic [mfm_pkg::TimeW-1:0] den_q, den_d;
  logic [mfm_pkg::QuotW-1:0] nsh_q, nsh_d;
  logic [mfm_pkg::QuotW-1:0] quot_q, quot_d;
  logic [CntW-1:0]           cnt_q, cnt_d;
  logic                      busy_q, busy_d;
  logic                      done_q, done_d;
  logic [mfm_pkg::TimeW:0]   shifted;
  logic [mfm_pkg::TimeW+1:0] trial;

  always_comb begin
    shifted = {rem_q, nsh_q[mfm_pkg::QuotW-1]};
    trial   = {1'b0, shifted} - {2'b00, den_q};
    rem_d   = rem_q;
    den_d   = den_q;
    nsh_d   = nsh_q;
    quot_d  = quot_q;
    cnt_d   = cnt_q;
    busy_d  = busy_q;
    done_d  = 1'b0;
    if (start_i) begin
      rem_d  = num_i[mfm_pkg::ProdW-1:mfm_pkg::QuotW];
      nsh_d  = num_i[mfm_pkg::QuotW-1:0];
      den_d  = den_i;
      quot_d = '0;
      cnt_d  = CntW'(mfm_pkg::QuotW);
      busy_d = 1'b1;
    end else if (busy_q) begin
      nsh_d = {nsh_q[mfm_pkg::QuotW-2:0], 1'b0};
      if (!trial[mfm_pkg::TimeW+1]) begin
        rem_d  = trial[mfm_pkg::TimeW-1:0];
        quot_d = {quot_q[mfm_pkg::QuotW-2:0], 1'b1};
      end else begin
        rem_d  = shifted[mfm_pkg::TimeW-1:0];
        quot_d = {quot_q[mfm_pkg::QuotW-2:0], 1'b0};
      end
      cnt_d = cnt_q - CntW'(1);
      if (cnt_q == CntW'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q  <= rem_d;
    den_q  <= den_d;
    nsh_q  <= nsh_d;
    quot_q <= quot_d;
  end

  assign done_o = done_q;
  assign quot_o = quot_q;

endmodule
`default_nettype wire

// ===== rtl/core/multi_slot_alpha_fade_mixer_top.sv =====
// Top level of the multi-slot alpha fade mixer with its slot table and sequencer.
// The block keeps a table of fade slots, each a constant weight or a linear ramp.
// The input channel carries one command per transaction: tick, add constant,
// add ramp or remove. The output channel returns exactly one result transaction
// per input transaction: combined alpha, assigned slot, accept flag and count.
// An add or a remove presents its result in the cycle after acceptance.
// A tick visits every slot in order with one shared multiplier and one
// bit-serial divider; a tick with no used slot goes straight to the output.
// A free or expiring slot is handled in StScan alone, a constant slot or one
// that holds its end weight in StScan and StAcc, and an interpolating slot in
// StScan, StMulR, StDiv and StAcc, where StDiv waits on the divider.
// Only one transaction is in flight: the input is ready only while idle.
// A result holds on the output until the receiver takes it; a stalled receiver
// holds the whole block. Reset frees all slots and empties the output.
`default_nettype none
module multi_slot_alpha_fade_mixer_top #(
  parameter int unsigned SLOTS = mfm_pkg::SlotsDefault
) (
  input  wire logic                                clk_i,
  input  wire logic                                rst_ni,
  input  wire logic                                in_valid_i,
  output logic                                     in_ready_o,
  input  wire logic [1:0]                          command_i,
  input  wire logic [2:0]                          slot_sel_i,
  input  wire logic [mfm_pkg::ElapsedW-1:0]        elapsed_i,
  input  wire logic [mfm_pkg::WeightW-1:0]         start_weight_i,
  input  wire logic [mfm_pkg::WeightW-1:0]         end_weight_i,
  input  wire logic [mfm_pkg::TimeW-1:0]           blend_time_i,
  input  wire logic [mfm_pkg::TimeW-1:0]           life_time_i,
  input  wire logic                                looping_i,
  output logic                                     out_valid_o,
  input  wire logic                                out_ready_i,
  output logic                                     alpha_valid_o,
  output logic      [mfm_pkg::WeightW-1:0]         alpha_o,
  output logic      [2:0]                          slot_given_o,
  output logic                                     accepted_o,
  output logic      [3:0]                          active_count_o
);

  localparam int unsigned IdxW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int unsigned CntW = $clog2(SLOTS + 1);
  localparam int unsigned WW   = mfm_pkg::WeightW;
  localparam int unsigned TW   = mfm_pkg::TimeW;

  mfm_pkg::state_e state_q, state_d;

  logic [SLOTS-1:0] used_q, used_d;
  logic [SLOTS-1:0] ramp_q, ramp_d;
  logic [SLOTS-1:0] loop_q, loop_d;
  logic [TW-1:0]    clock_q [SLOTS];
  logic [WW-1:0]    start_q [SLOTS];
  logic [WW-1:0]    end_q   [SLOTS];
  logic [WW-1:0]    now_q   [SLOTS];
  logic [TW-1:0]    blend_q [SLOTS];
  logic [TW-1:0]    life_q  [SLOTS];

  logic [IdxW-1:0]  idx_q, idx_d;
  logic [mfm_pkg::ElapsedW-1:0] elapsed_q, elapsed_d;
  logic [WW-1:0]    acc_q, acc_d;
  logic             up_q, up_d;
  logic             aval_q, aval_d;
  logic [WW-1:0]    alpha_q, alpha_d;
  logic [2:0]       given_q, given_d;
  logic             ok_q, ok_d;

  logic             wr_add, wr_clock, wr_now;
  logic [IdxW-1:0]  wr_idx;
  logic [TW-1:0]    clock_wd;
  logic [WW-1:0]    now_wd;
  logic             add_ramp;

  logic [WW-1:0]    w0, w1;
  logic [TW:0]      clk_sum;
  logic [TW-1:0]    clk_sat;
  logic [WW-1:0]    diff;
  logic [TW-1:0]    mul_a;
  logic [WW-1:0]    mul_b;
  logic [mfm_pkg::ProdW-1:0] prod;
  logic [CntW-1:0]  count;
  logic             free_found;
  logic [IdxW-1:0]  free_idx;
  logic [IdxW-1:0]  sel_idx;
  logic             sel_in_range;
  logic             last;

  logic             div_start;
  logic             div_done;
  logic [mfm_pkg::QuotW-1:0] quot;

  mfm_divider u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .num_i   (prod),
    .den_i   (blend_q[idx_q]),
    .done_o  (div_done),
    .quot_o  (quot)
  );

  always_comb begin
    count      = '0;
    free_found = 1'b0;
    free_idx   = '0;
    for (int i = 0; i < SLOTS; i++) begin
      count = count + CntW'(used_q[i]);
      if (!used_q[i] && !free_found) begin
        free_found = 1'b1;
        free_idx   = IdxW'(i);
      end
    end
  end

  assign w0 = (start_weight_i > mfm_pkg::OneQ16) ? mfm_pkg::OneQ16 : start_weight_i;
  assign w1 = (end_weight_i > mfm_pkg::OneQ16) ? mfm_pkg::OneQ16 : end_weight_i;
  assign sel_idx      = IdxW'(slot_sel_i);
  assign sel_in_range = (32'(slot_sel_i) < SLOTS);
  assign last         = (32'(idx_q) == SLOTS - 1);

  assign clk_sum = {1'b0, clock_q[idx_q]} + (TW + 1)'(elapsed_q);
  assign clk_sat = clk_sum[TW] ? mfm_pkg::ClockMax : clk_sum[TW-1:0];
  assign diff    = up_q ? (end_q[idx_q] - start_q[idx_q]) : (start_q[idx_q] - end_q[idx_q]);

  always_comb begin
    if (state_q == mfm_pkg::StMulR) begin
      mul_a = clock_q[idx_q];
      mul_b = diff;
    end else begin
      mul_a = TW'(acc_q);
      mul_b = now_q[idx_q];
    end
  end
  assign prod = mfm_pkg::ProdW'(mul_a) * mfm_pkg::ProdW'(mul_b);

  always_comb begin
    state_d   = state_q;
    used_d    = used_q;
    ramp_d    = ramp_q;
    loop_d    = loop_q;
    idx_d     = idx_q;
    elapsed_d = elapsed_q;
    acc_d     = acc_q;
    up_d      = up_q;
    aval_d    = aval_q;
    alpha_d   = alpha_q;
    given_d   = given_q;
    ok_d      = ok_q;
    wr_add    = 1'b0;
    add_ramp  = 1'b0;
    wr_clock  = 1'b0;
    wr_now    = 1'b0;
    wr_idx    = idx_q;
    clock_wd  = clk_sat;
    now_wd    = end_q[idx_q];
    div_start = 1'b0;

    unique case (state_q)
      mfm_pkg::StIdle: begin
        if (in_valid_i) begin
          aval_d    = 1'b0;
          alpha_d   = '0;
          given_d   = '0;
          ok_d      = 1'b0;
          elapsed_d = elapsed_i;
          state_d   = mfm_pkg::StOut;
          unique case (mfm_pkg::cmd_e'(command_i))
            mfm_pkg::CmdTick: begin
              if (count != '0) begin
                aval_d  = 1'b1;
                acc_d   = mfm_pkg::OneQ16;
                idx_d   = '0;
                state_d = mfm_pkg::StScan;
              end
            end
            mfm_pkg::CmdAddConst, mfm_pkg::CmdAddRamp: begin
              if (free_found) begin
                wr_add           = 1'b1;
                add_ramp         = (mfm_pkg::cmd_e'(command_i) == mfm_pkg::CmdAddRamp);
                wr_idx           = free_idx;
                used_d[free_idx] = 1'b1;
                ramp_d[free_idx] = add_ramp;
                loop_d[free_idx] = looping_i;
                given_d          = 3'(free_idx);
                ok_d             = 1'b1;
              end
            end
            mfm_pkg::CmdRemove: begin
              if (sel_in_range && used_q[sel_idx]) begin
                used_d[sel_idx] = 1'b0;
                ramp_d[sel_idx] = 1'b0;
                ok_d            = 1'b1;
              end
            end
            default: ;
          endcase
        end
      end
      mfm_pkg::StScan: begin
        if (!used_q[idx_q]) begin
          if (last) begin
            alpha_d = acc_q;
            state_d = mfm_pkg::StOut;
          end else begin
            idx_d = idx_q + IdxW'(1);
          end
        end else begin
          wr_clock = 1'b1;
          if (!loop_q[idx_q] && clk_sat >= life_q[idx_q]) begin
            used_d[idx_q] = 1'b0;
            ramp_d[idx_q] = 1'b0;
            if (last) begin
              alpha_d = acc_q;
              state_d = mfm_pkg::StOut;
            end else begin
              idx_d = idx_q + IdxW'(1);
            end
          end else if (ramp_q[idx_q] && clk_sat >= blend_q[idx_q]) begin
            wr_now        = 1'b1;
            now_wd        = end_q[idx_q];
            ramp_d[idx_q] = 1'b0;
            state_d       = mfm_pkg::StAcc;
          end else if (ramp_q[idx_q]) begin
            up_d    = (end_q[idx_q] >= start_q[idx_q]);
            state_d = mfm_pkg::StMulR;
          end else begin
            state_d = mfm_pkg::StAcc;
          end
        end
      end
      mfm_pkg::StMulR: begin
        div_start = 1'b1;
        state_d   = mfm_pkg::StDiv;
      end
      mfm_pkg::StDiv: begin
        if (div_done) begin
          wr_now  = 1'b1;
          now_wd  = up_q ? (start_q[idx_q] + quot) : (start_q[idx_q] - quot);
          state_d = mfm_pkg::StAcc;
        end
      end
      mfm_pkg::StAcc: begin
        acc_d = prod[WW+15:16];
        if (last) begin
          alpha_d = prod[WW+15:16];
          state_d = mfm_pkg::StOut;
        end else begin
          idx_d   = idx_q + IdxW'(1);
          state_d = mfm_pkg::StScan;
        end
      end
      mfm_pkg::StOut: begin
        if (out_ready_i) begin
          state_d = mfm_pkg::StIdle;
        end
      end
      default: state_d = mfm_pkg::StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= mfm_pkg::StIdle;
      used_q  <= '0;
      ramp_q  <= '0;
      loop_q  <= '0;
    end else begin
      state_q <= state_d;
      used_q  <= used_d;
      ramp_q  <= ramp_d;
      loop_q  <= loop_d;
    end
  end

  always_ff @(posedge clk_i) begin
    idx_q     <= idx_d;
    elapsed_q <= elapsed_d;
    acc_q     <= acc_d;
    up_q      <= up_d;
    aval_q    <= aval_d;
    alpha_q   <= alpha_d;
    given_q   <= given_d;
    ok_q      <= ok_d;
    if (wr_add) begin
      clock_q[wr_idx] <= '0;
      start_q[wr_idx] <= w0;
      now_q[wr_idx]   <= w0;
      life_q[wr_idx]  <= life_time_i;
      end_q[wr_idx]   <= add_ramp ? w1 : w0;
      blend_q[wr_idx] <= add_ramp ? blend_time_i : '0;
    end
    if (wr_clock) begin
      clock_q[wr_idx] <= clock_wd;
    end
    if (wr_now) begin
      now_q[wr_idx] <= now_wd;
    end
  end

  assign in_ready_o     = (state_q == mfm_pkg::StIdle);
  assign out_valid_o    = (state_q == mfm_pkg::StOut);
  assign alpha_valid_o  = aval_q;
  assign alpha_o        = alpha_q;
  assign slot_given_o   = given_q;
  assign accepted_o     = ok_q;
  assign active_count_o = 4'(count);

endmodule
`default_nettype wire
